// ----- hdl/imf_register_write_sequencer_assert.svh -----
// Assertion macros for the IMF register write sequencer.
// Used by the top level; expects clk and arst_n in scope.
`ifndef IMF_REGISTER_WRITE_SEQUENCER_ASSERT_SVH
`define IMF_REGISTER_WRITE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define IMF_RWS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("imf_rws: same-cycle property violated");

// Next-cycle implication.
`define IMF_RWS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("imf_rws: next-cycle property violated");

`endif

// ----- hdl/imf_rws_pkg.sv -----
// Shared types and constants for the IMF register write sequencer.
// No dependencies; used by imf_rws_div and the top level.
`default_nettype none

package imf_rws_pkg;

	localparam int MAX_EVENTS = 16384;
	localparam int MAX_BURST  = 64;

	localparam int ADDR_W   = 14;
	localparam int POS_W    = 15;
	localparam int BURST_W  = $clog2(MAX_BURST + 1);
	localparam int EVENT_W  = 32;
	localparam int TICK_W   = 32;
	localparam int DELAY_W  = 16;
	localparam int SR_W     = 17;
	localparam int TR_W     = 10;
	localparam int ACC_W    = 17;
	localparam int FRAMES_W = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// Restoring division: one quotient bit per step.
	localparam int DIV_STEPS  = ACC_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	localparam logic [POS_W-1:0] COUNT_MAX = POS_W'(MAX_EVENTS);
	localparam logic [SR_W-1:0]  SR_MIN    = SR_W'(8000);
	localparam logic [SR_W-1:0]  SR_MAX    = SR_W'(96000);
	localparam logic [SR_W-1:0]  SR_RESET  = SR_W'(48000);
	localparam logic [TR_W-1:0]  TR_MIN    = TR_W'(100);
	localparam logic [TR_W-1:0]  TR_MAX    = TR_W'(1000);
	localparam logic [TR_W-1:0]  TR_RESET  = TR_W'(700);

	// Item kinds carried in s_tuser.
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_DATA,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT_RD,
		ST_EMIT_DATA,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic              start;
		logic [ACC_W-1:0]  dividend;
		logic [TR_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [FRAMES_W-1:0] quotient;
		logic [TR_W-1:0]     remainder;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/imf_rws_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module imf_rws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/imf_rws_div.sv -----
// Iterative restoring divider that works out frames per tick and the carried remainder.
// Depends on imf_rws_pkg.
`default_nettype none

module imf_rws_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire imf_rws_pkg::div_req_t req,
	output imf_rws_pkg::div_rsp_t      rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [imf_rws_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [imf_rws_pkg::TR_W-1:0]        rem_q;
	logic [imf_rws_pkg::ACC_W-1:0]       quo_q;
	logic [imf_rws_pkg::TR_W-1:0]        dvs_q;
	logic [imf_rws_pkg::TR_W:0]          trial;
	logic [imf_rws_pkg::TR_W:0]          diff;
	logic                                fits;

	// Partial remainder stays below the divisor, so it fits TR_W bits after each step.
	assign trial = {rem_q, quo_q[imf_rws_pkg::ACC_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == imf_rws_pkg::DIV_CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= imf_rws_pkg::DIV_CNT_W'(imf_rws_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - imf_rws_pkg::DIV_CNT_W'(1);
				if (cnt_q == imf_rws_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[imf_rws_pkg::TR_W-1:0] : trial[imf_rws_pkg::TR_W-1:0];
			quo_q <= {quo_q[imf_rws_pkg::ACC_W-2:0], fits};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q[imf_rws_pkg::FRAMES_W-1:0];
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

// ----- hdl/imf_register_write_sequencer.sv -----
// IMF register write sequencer: plays stored events as OPL register writes, one tick per item.
// Depends on imf_rws_pkg, imf_rws_ram, imf_rws_div and the assertion header.
// Load, start and unknown items give no result word. A tick with due events scans the event RAM,
// runs the divider (skipped when the script ends without looping), then replays the writes, or
// gives a lone word; a finished or empty script gives one word. Result stalls hold the replay.
// Reset clears playback state and registers, not the event RAM.
`default_nettype none

`include "imf_register_write_sequencer_assert.svh"

module imf_register_write_sequencer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input words
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [47:0]                         s_tdata,  // event_index, event_reg, event_val, event_delay
	input  wire logic [1:0]                          s_tuser,  // mode
	// Result words
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [31:0]                              m_tdata,  // opl_reg, opl_value, frames_in_tick, finished
	output logic                                     m_tuser,  // write_valid
	output logic                                     m_tlast,
	// Configuration writes
	input  wire logic                                cfg_we,
	input  wire logic [imf_rws_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [imf_rws_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int POS_W   = imf_rws_pkg::POS_W;
	localparam int BURST_W = imf_rws_pkg::BURST_W;
	localparam int TICK_W  = imf_rws_pkg::TICK_W;

	imf_rws_pkg::state_t state_q, state_d;

	// Configuration
	logic [POS_W-1:0]                  count_cfg_q;
	logic                              loop_q;
	logic [imf_rws_pkg::SR_W-1:0]      sr_q;
	logic [imf_rws_pkg::TR_W-1:0]      tr_q;

	// Playback state
	logic [POS_W-1:0]                  pos_q;
	logic [TICK_W-1:0]                 tick_q;
	logic [TICK_W-1:0]                 next_q;
	logic [imf_rws_pkg::TR_W-1:0]      rem_q;
	logic                              done_q;

	// Per-tick working registers
	logic [POS_W-1:0]                  start_q;
	logic [BURST_W-1:0]                burst_q;
	logic [BURST_W-1:0]                emit_k_q;
	logic [imf_rws_pkg::FRAMES_W-1:0]  frames_q;

	// Output register
	logic                              out_valid_q;
	logic                              out_wv_q;
	logic [7:0]                        out_reg_q;
	logic [7:0]                        out_val_q;
	logic [imf_rws_pkg::FRAMES_W-1:0]  out_frames_q;
	logic                              out_fin_q;
	logic                              out_last_q;

	logic [POS_W-1:0]                  cnt_act;
	logic [imf_rws_pkg::SR_W-1:0]      sr_sat;
	logic [imf_rws_pkg::TR_W-1:0]      tr_sat;
	logic                              in_acc;
	logic                              out_free;
	logic                              scan_go;
	logic                              at_end;
	logic                              emit_last;
	logic [POS_W-1:0]                  emit_pos;
	logic [imf_rws_pkg::ADDR_W-1:0]    raddr;
	logic [imf_rws_pkg::EVENT_W-1:0]   rdata;
	logic                              load_emit;
	logic                              load_final;
	imf_rws_pkg::div_req_t             div_req;
	imf_rws_pkg::div_rsp_t             div_rsp;

	assign cnt_act = (count_cfg_q > imf_rws_pkg::COUNT_MAX) ? imf_rws_pkg::COUNT_MAX : count_cfg_q;
	assign sr_sat  = (sr_q < imf_rws_pkg::SR_MIN) ? imf_rws_pkg::SR_MIN :
	                 ((sr_q > imf_rws_pkg::SR_MAX) ? imf_rws_pkg::SR_MAX : sr_q);
	assign tr_sat  = (tr_q < imf_rws_pkg::TR_MIN) ? imf_rws_pkg::TR_MIN :
	                 ((tr_q > imf_rws_pkg::TR_MAX) ? imf_rws_pkg::TR_MAX : tr_q);

	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign at_end    = (pos_q >= cnt_act);
	assign scan_go   = !at_end && (burst_q < BURST_W'(imf_rws_pkg::MAX_BURST)) &&
	                   (next_q <= tick_q);
	assign emit_last = ((emit_k_q + BURST_W'(1)) == burst_q);
	assign emit_pos  = start_q + {{(POS_W-BURST_W){1'b0}}, emit_k_q};

	imf_rws_ram #(
		.WIDTH (imf_rws_pkg::EVENT_W),
		.DEPTH (imf_rws_pkg::MAX_EVENTS)
	) u_event_ram (
		.clk   (clk),
		.we    (in_acc && (s_tuser == imf_rws_pkg::MODE_LOAD)),
		.waddr (s_tdata[13:0]),
		.wdata ({s_tdata[45:30], s_tdata[29:22], s_tdata[21:14]}),
		.raddr (raddr),
		.rdata (rdata)
	);

	imf_rws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imf_rws_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		s_tready         = 1'b0;
		raddr            = pos_q[imf_rws_pkg::ADDR_W-1:0];
		div_req.start    = 1'b0;
		div_req.dividend = {{(imf_rws_pkg::ACC_W-imf_rws_pkg::TR_W){1'b0}}, rem_q} + sr_sat;
		div_req.divisor  = tr_sat;
		load_emit        = 1'b0;
		load_final       = 1'b0;
		unique case (state_q)
			imf_rws_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (s_tuser == imf_rws_pkg::MODE_TICK)) begin
					if (done_q || (cnt_act == '0)) begin
						state_d = imf_rws_pkg::ST_FINAL;
					end else begin
						state_d = imf_rws_pkg::ST_SCAN;
					end
				end
			end
			imf_rws_pkg::ST_SCAN: begin
				if (scan_go) begin
					state_d = imf_rws_pkg::ST_SCAN_DATA;
				end else if (at_end && !loop_q) begin
					state_d = (burst_q == '0) ? imf_rws_pkg::ST_FINAL : imf_rws_pkg::ST_EMIT_RD;
				end else begin
					state_d = imf_rws_pkg::ST_DIV_START;
				end
			end
			imf_rws_pkg::ST_SCAN_DATA: begin
				state_d = imf_rws_pkg::ST_SCAN;
			end
			imf_rws_pkg::ST_DIV_START: begin
				div_req.start = 1'b1;
				state_d       = imf_rws_pkg::ST_DIV_WAIT;
			end
			imf_rws_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = (burst_q == '0) ? imf_rws_pkg::ST_FINAL : imf_rws_pkg::ST_EMIT_RD;
				end
			end
			imf_rws_pkg::ST_EMIT_RD: begin
				raddr = emit_pos[imf_rws_pkg::ADDR_W-1:0];
				// Only read once the output register will be free when the data arrives.
				if (out_free) begin
					state_d = imf_rws_pkg::ST_EMIT_DATA;
				end
			end
			imf_rws_pkg::ST_EMIT_DATA: begin
				load_emit = 1'b1;
				state_d   = emit_last ? imf_rws_pkg::ST_IDLE : imf_rws_pkg::ST_EMIT_RD;
			end
			imf_rws_pkg::ST_FINAL: begin
				if (out_free) begin
					load_final = 1'b1;
					state_d    = imf_rws_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = imf_rws_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_cfg_q <= '0;
			loop_q      <= 1'b0;
			sr_q        <= imf_rws_pkg::SR_RESET;
			tr_q        <= imf_rws_pkg::TR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				imf_rws_pkg::REG_EVENT_COUNT: count_cfg_q <= cfg_wdata[POS_W-1:0];
				imf_rws_pkg::REG_LOOP_ENABLE: loop_q      <= cfg_wdata[0];
				imf_rws_pkg::REG_SAMPLE_RATE: sr_q        <= cfg_wdata[imf_rws_pkg::SR_W-1:0];
				imf_rws_pkg::REG_TICK_RATE:   tr_q        <= cfg_wdata[imf_rws_pkg::TR_W-1:0];
				default: ;
			endcase
		end
	end

	// Playback state and per-tick bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			tick_q   <= '0;
			next_q   <= '0;
			rem_q    <= '0;
			done_q   <= 1'b0;
			start_q  <= '0;
			burst_q  <= '0;
			emit_k_q <= '0;
			frames_q <= '0;
		end else begin
			unique case (state_q)
				imf_rws_pkg::ST_IDLE: begin
					if (in_acc && (s_tuser == imf_rws_pkg::MODE_START)) begin
						pos_q  <= '0;
						tick_q <= '0;
						next_q <= '0;
						rem_q  <= '0;
						done_q <= (cnt_act == '0);
					end else if (in_acc && (s_tuser == imf_rws_pkg::MODE_TICK)) begin
						start_q  <= pos_q;
						burst_q  <= '0;
						emit_k_q <= '0;
						frames_q <= '0;
						if (cnt_act == '0) begin
							done_q <= 1'b1;
						end
					end
				end
				imf_rws_pkg::ST_SCAN: begin
					if (!scan_go) begin
						// End of the due burst: a looping script at its end rewinds, otherwise the tick
						// clock advances and a finished script is flagged.
						if (at_end && loop_q) begin
							pos_q  <= '0;
							next_q <= '0;
							tick_q <= '0;
						end else begin
							tick_q <= tick_q + TICK_W'(1);
							if (at_end) begin
								done_q <= 1'b1;
							end
						end
					end
				end
				imf_rws_pkg::ST_SCAN_DATA: begin
					next_q  <= tick_q + {{(TICK_W-imf_rws_pkg::DELAY_W){1'b0}}, rdata[31:16]};
					pos_q   <= pos_q + POS_W'(1);
					burst_q <= burst_q + BURST_W'(1);
				end
				imf_rws_pkg::ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						frames_q <= div_rsp.quotient;
						rem_q    <= div_rsp.remainder;
					end
				end
				imf_rws_pkg::ST_EMIT_DATA: begin
					emit_k_q <= emit_k_q + BURST_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_emit || load_final) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_emit) begin
			out_wv_q     <= 1'b1;
			out_reg_q    <= rdata[7:0];
			out_val_q    <= rdata[15:8];
			out_frames_q <= emit_last ? frames_q : '0;
			out_fin_q    <= done_q;
			out_last_q   <= emit_last;
		end else if (load_final) begin
			out_wv_q     <= 1'b0;
			out_reg_q    <= '0;
			out_val_q    <= '0;
			out_frames_q <= frames_q;
			out_fin_q    <= done_q;
			out_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_fin_q, out_frames_q, out_val_q, out_reg_q};
	assign m_tuser  = out_wv_q;
	assign m_tlast  = out_last_q;

	`IMF_RWS_ASSERT_NOW(a_emit_slot_free, state_q == imf_rws_pkg::ST_EMIT_DATA, !out_valid_q)
	`IMF_RWS_ASSERT_NOW(a_burst_bound, state_q != imf_rws_pkg::ST_IDLE, burst_q <= BURST_W'(imf_rws_pkg::MAX_BURST))
	`IMF_RWS_ASSERT_NOW(a_emit_index, state_q == imf_rws_pkg::ST_EMIT_DATA, emit_k_q < burst_q)
	`IMF_RWS_ASSERT_NEXT(a_load_sets_valid, load_emit || load_final, out_valid_q)

endmodule

`default_nettype wire

// ----- tb/sv/imf_register_write_sequencer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the IMF register write sequencer: stream stimulus, a scoreboard
// with its own playback predictor, random idling on both stream sides. Needs only imf_rws_pkg
// and the sequencer RTL.

module imf_register_write_sequencer_tb;
	import imf_rws_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 16;
	localparam int END_CYCLES    = 64;
	localparam int LONG_HOLD     = 300;
	localparam int ITEM_TARGET   = 310;
	localparam int BURST_SCRIPT  = 70;
	// Worst case: every word a full burst, every result behind the longest receiver stall.
	localparam int CYCLE_LIMIT   = 5000000;

	typedef struct packed {
		bit       wr;
		bit [7:0] opl_reg;
		bit [7:0] opl_value;
		bit [9:0] frames;
		bit       fin;
		bit       is_last;
	} opl_word_t;

	class opl_write_scoreboard;
		bit [31:0]   event_mem [MAX_EVENTS];
		bit [14:0]   play_pos;
		bit [31:0]   tick_now;
		bit [31:0]   next_due;
		bit [9:0]    frame_rem;
		bit          finished_flag;
		bit [14:0]   cfg_count;
		bit          cfg_loop;
		bit [16:0]   cfg_sr;
		bit [9:0]    cfg_tr;
		opl_word_t   expected_writes[$];
		int unsigned mismatches;
		int unsigned words_checked;
		int unsigned writes_checked;
		int unsigned ticks_seen;
		int unsigned lines_printed;

		function new();
			cfg_sr = SR_RESET;
			cfg_tr = TR_RESET;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_EVENT_COUNT: cfg_count = val[14:0];
				REG_LOOP_ENABLE: cfg_loop = val[0];
				REG_SAMPLE_RATE: cfg_sr = val;
				REG_TICK_RATE:   cfg_tr = val[9:0];
				default: ;
			endcase
		endfunction

		function bit [14:0] active_count();
			return (cfg_count > COUNT_MAX) ? COUNT_MAX : cfg_count;
		endfunction

		function opl_word_t make_word(bit wr, bit [7:0] rg, bit [7:0] vl);
			opl_word_t w;
			w = '0;
			w.wr = wr;
			w.opl_reg = rg;
			w.opl_value = vl;
			return w;
		endfunction

		function void play_tick();
			bit [14:0] span;
			bit [31:0] ev;
			bit [16:0] sr;
			bit [16:0] tr;
			bit [16:0] acc;
			bit [9:0]  frames;
			opl_word_t burst[$];
			opl_word_t w;
			ticks_seen++;
			if (finished_flag) begin
				w = make_word(1'b0, 8'h00, 8'h00);
				w.fin = 1'b1;
				w.is_last = 1'b1;
				expected_writes.push_back(w);
				return;
			end
			span = active_count();
			frames = '0;
			if (span == 0) begin
				finished_flag = 1'b1;
			end else begin
				while (play_pos < span && burst.size() < MAX_BURST && next_due <= tick_now) begin
					ev = event_mem[play_pos[13:0]];
					next_due = tick_now + {16'h0000, ev[31:16]};
					burst.push_back(make_word(1'b1, ev[7:0], ev[15:8]));
					play_pos++;
				end
				tick_now++;
				if (play_pos >= span) begin
					if (!cfg_loop) begin
						finished_flag = 1'b1;
					end else begin
						play_pos = '0;
						next_due = '0;
						tick_now = '0;
					end
				end
			end
			if (!finished_flag) begin
				sr = (cfg_sr < SR_MIN) ? SR_MIN : ((cfg_sr > SR_MAX) ? SR_MAX : cfg_sr);
				tr = (cfg_tr < TR_MIN) ? 17'(TR_MIN) : ((cfg_tr > TR_MAX) ? 17'(TR_MAX) : 17'(cfg_tr));
				acc = 17'(frame_rem) + sr;
				frames = 10'(acc / tr);
				frame_rem = 10'(acc % tr);
			end
			if (burst.size() == 0)
				burst.push_back(make_word(1'b0, 8'h00, 8'h00));
			foreach (burst[k]) begin
				w = burst[k];
				w.fin = finished_flag;
				if (k == burst.size() - 1) begin
					w.frames = frames;
					w.is_last = 1'b1;
				end
				expected_writes.push_back(w);
			end
		endfunction

		function void note_word(logic [1:0] mode, logic [13:0] idx, logic [7:0] rg,
				logic [7:0] vl, logic [15:0] dl);
			case (mode)
				MODE_LOAD: event_mem[idx] = {dl, vl, rg};
				MODE_START: begin
					play_pos = '0;
					tick_now = '0;
					next_due = '0;
					frame_rem = '0;
					finished_flag = (active_count() == 0);
				end
				MODE_TICK: play_tick();
				default: ;
			endcase
		endfunction

		task report(string field, int unsigned got, int unsigned want);
			mismatches++;
			if (lines_printed < 40) begin
				$display("mismatch in %s at result word %0d: got 0x%0h, expected 0x%0h",
					field, words_checked, got, want);
				lines_printed++;
			end
		endtask

		task check_word(opl_word_t got);
			opl_word_t want;
			if (expected_writes.size() == 0) begin
				report("result word with nothing expected", got, 0);
				return;
			end
			want = expected_writes.pop_front();
			words_checked++;
			if (want.wr)
				writes_checked++;
			if (got.wr != want.wr)
				report("write_valid", got.wr, want.wr);
			if (got.opl_reg != want.opl_reg)
				report("opl_reg", got.opl_reg, want.opl_reg);
			if (got.opl_value != want.opl_value)
				report("opl_value", got.opl_value, want.opl_value);
			if (got.frames != want.frames)
				report("frames_in_tick", got.frames, want.frames);
			if (got.fin != want.fin)
				report("finished", got.fin, want.fin);
			if (got.is_last != want.is_last)
				report("tlast", got.is_last, want.is_last);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata = '0;   // event_index, event_reg, event_val, event_delay
	logic [1:0]            s_tuser = '0;   // mode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;        // opl_reg, opl_value, frames_in_tick, finished
	logic                  m_tuser;        // write_valid
	logic                  m_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	opl_write_scoreboard sb;
	int unsigned words_sent;
	int unsigned loaded_upto;
	int unsigned phases_run;
	int unsigned cycle_count;
	int unsigned stall_left;
	int unsigned hold_req;
	bit          tx_free;
	bit          rx_free;

	imf_register_write_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d result words still expected",
				cycle_count, sb.expected_writes.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side: check accepted words, then pick tready for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_word({m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[25:16],
					m_tdata[26], m_tlast});
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (rx_free || $urandom_range(0, 99) < 70) begin
				m_tready <= 1'b1;
			end else begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
					: $urandom_range(0, 2);
				m_tready <= 1'b0;
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tx_free || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [15:0] pick_delay();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 16'd0;
		if (r < 80)
			return 16'($urandom_range(1, 3));
		if (r < 95)
			return 16'($urandom_range(4, 20));
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [16:0] pick_rate(int unsigned lo, int unsigned hi, int unsigned top);
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return 17'(top);
			2: return 17'(lo);
			3: return 17'(hi);
			default: return 17'($urandom_range(lo, hi));
		endcase
	endfunction

	task automatic send_word(input logic [1:0] mode, input logic [13:0] idx,
			input logic [7:0] rg, input logic [7:0] vl, input logic [15:0] dl);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {2'b00, dl, vl, rg, idx};
		do @(posedge clk); while (!s_tready);
		sb.note_word(mode, idx, rg, vl, dl);
		if (mode != MODE_UNUSED)
			words_sent++;
	endtask

	// Start, tick and unknown words carry random filler in the unused fields.
	task automatic send_other(input logic [1:0] mode);
		send_word(mode, 14'($urandom_range(0, 16383)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
	endtask

	task automatic await_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.expected_writes.size() != 0);
	endtask

	// Loads and starts give no result word, so allow them to finish before a register write.
	task automatic drain();
		await_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_settings(input logic [16:0] count, input logic [16:0] loop_on,
			input logic [16:0] sr, input logic [16:0] tr);
		put_reg(REG_EVENT_COUNT, count);
		put_reg(REG_LOOP_ENABLE, loop_on);
		put_reg(REG_SAMPLE_RATE, sr);
		put_reg(REG_TICK_RATE, tr);
		cfg_we <= 1'b0;
	endtask

	// Loads slots 0..n-1 with unknown words and loads to unplayed high slots mixed in.
	task automatic load_script(input int unsigned n, input bit zero_delay);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 15) begin
				if ($urandom_range(0, 1))
					send_other(MODE_UNUSED);
				else
					send_word(MODE_LOAD, 14'($urandom_range(128, 16383)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						16'($urandom_range(0, 65535)));
			end
			send_word(MODE_LOAD, 14'(i), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				zero_delay ? 16'd0 : pick_delay());
		end
		if (n > loaded_upto)
			loaded_upto = n;
	endtask

	task automatic run_directed();
		// Reset settings hold an empty script: the first tick already finishes it.
		send_other(MODE_TICK);
		send_word(MODE_UNUSED, 14'h3FFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_other(MODE_START);
		send_other(MODE_TICK);
		send_word(MODE_LOAD, 14'd0, 8'hFF, 8'h00, 16'h0000);
		send_word(MODE_LOAD, 14'd1, 8'h00, 8'hFF, 16'h0001);
		send_word(MODE_LOAD, 14'd2, 8'hA5, 8'h5A, 16'hFFFF);
		send_word(MODE_LOAD, 14'd3, 8'h3C, 8'hC3, 16'h0002);
		send_word(MODE_LOAD, 14'h3FFF, 8'hFF, 8'hFF, 16'hFFFF);
		loaded_upto = 4;

		// Three events, no loop, fastest frame rate: the script ends on the second tick.
		drain();
		apply_settings(17'd3, 17'd0, SR_MAX, 17'(TR_MIN));
		send_other(MODE_START);
		repeat (4) send_other(MODE_TICK);

		// Count above the memory size, sample rate below its floor and tick rate above its ceiling.
		drain();
		apply_settings(17'h7FFF, 17'd1, 17'd0, 17'h3FF);
		send_other(MODE_START);
		repeat (3) send_other(MODE_TICK);

		// Count lowered under the play position without a restart.
		drain();
		apply_settings(17'd2, 17'd1, 17'h1FFFF, 17'd0);
		send_other(MODE_TICK);

		drain();
		apply_settings(17'(MAX_EVENTS), 17'd0, SR_MIN, 17'(TR_MAX));
		send_other(MODE_START);
		send_other(MODE_TICK);
	endtask

	task automatic run_random();
		int unsigned phase_no;
		int unsigned n;
		int unsigned ticks;
		int unsigned r;
		bit          fresh;
		phase_no = 0;
		while (words_sent < ITEM_TARGET) begin
			drain();
			tx_free = ($urandom_range(0, 3) == 0);
			rx_free = ($urandom_range(0, 3) == 0);
			if (phase_no == 0) begin
				// More due events than one tick may emit.
				fresh = 1'b1;
				n = BURST_SCRIPT;
			end else begin
				fresh = ($urandom_range(0, 9) < 6);
				n = fresh ? $urandom_range(1, 12) : $urandom_range(0, loaded_upto);
			end
			apply_settings(17'(n), 17'($urandom_range(0, 1)), pick_rate(8000, 96000, 17'h1FFFF),
				pick_rate(100, 1000, 10'h3FF));
			if (fresh)
				load_script(n, phase_no == 0);
			if (fresh || $urandom_range(0, 3) != 0)
				send_other(MODE_START);
			// A long receiver hold-off while ticks keep coming fills the block up.
			if (phase_no == 2 || $urandom_range(0, 9) == 0)
				hold_req = LONG_HOLD;
			ticks = (phase_no == 0) ? 3 : $urandom_range(4, 16);
			for (int unsigned t = 0; t < ticks; t++) begin
				r = $urandom_range(0, 99);
				if (r < 6)
					send_word(MODE_LOAD, 14'($urandom_range(0, loaded_upto - 1)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_delay());
				else if (r < 10)
					send_other(MODE_START);
				else if (r < 14)
					send_other(MODE_UNUSED);
				if ((phase_no == 1 && t == ticks / 2) || $urandom_range(0, 29) == 0)
					await_results();
				send_other(MODE_TICK);
			end
			phase_no++;
		end
		phases_run = phase_no;
	endtask

	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		await_results();
		repeat (END_CYCLES) @(posedge clk);
		$display("Sent %0d words over %0d random setting phases after the directed part;",
			words_sent, phases_run);
		$display("checked %0d result words from %0d ticks, %0d of them OPL register writes.",
			sb.words_checked, sb.ticks_seen, sb.writes_checked);
		if (sb.mismatches == 0 && sb.expected_writes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
